/* hw/rtl/bpc_pkg.sv */
package bpc_pkg;

  localparam int unsigned RawW      = 24;
  localparam int unsigned CalW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned DtW       = 25;
  localparam int unsigned CoefProdW = 42;
  localparam int unsigned DtSqW     = 50;
  localparam int unsigned T2W       = 17;
  localparam int unsigned TempW     = 19;
  localparam int unsigned TempExtW  = 20;
  localparam int unsigned TempSqW   = 40;
  localparam int unsigned SqW       = 36;
  localparam int unsigned OffW      = 40;
  localparam int unsigned PartW     = 20;
  localparam int unsigned PartLoW   = RawW + PartW;
  localparam int unsigned PartHiW   = RawW + 1 + OffW - PartW;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned DiffW     = 45;
  localparam int unsigned PressW    = 32;
  localparam int unsigned NumStages = 10;

  localparam logic signed [TempW-1:0] TempBase    = 19'sd2000;
  localparam logic signed [TempW-1:0] TempVeryLow = -19'sd1500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgC1   = 3'd0,
    CfgC2   = 3'd1,
    CfgC3   = 3'd2,
    CfgC4   = 3'd3,
    CfgC5   = 3'd4,
    CfgC6   = 3'd5,
    CfgSoEn = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
    logic            so_en;
  } cal_t;

  typedef logic [NumStages-1:0] stage_en_t;

  // Hand-off from the coefficient stages to the pressure stages.
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [OffW-1:0]  off;
    logic signed [OffW-1:0]  sens;
    logic signed [TempW-1:0] temp;
  } coef_res_t;

endpackage

/* hw/rtl/bpc_in_if.sv */
interface bpc_in_if;
  import bpc_pkg::*;

  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressure;
  logic [RawW-1:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink   (input valid, raw_pressure, raw_temperature, output ready);

endinterface

/* hw/rtl/bpc_out_if.sv */
interface bpc_out_if;
  import bpc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PressW-1:0] pressure_centi_mbar;
  logic signed [TempW-1:0]  temperature_centi_deg;

  modport source (output valid, pressure_centi_mbar, temperature_centi_deg, input ready);
  modport sink   (input valid, pressure_centi_mbar, temperature_centi_deg, output ready);

endinterface

/* hw/rtl/bpc_cfg_if.sv */
interface bpc_cfg_if;
  import bpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CalW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

/* hw/rtl/bpc_cfg_regs.sv */
module bpc_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  bpc_cfg_if.sink        cfg_i,
  output bpc_pkg::cal_t  cal_o
);
  import bpc_pkg::*;

  cal_t cal_d, cal_q;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgC1:   cal_d.c1    = cfg_i.data;
        CfgC2:   cal_d.c2    = cfg_i.data;
        CfgC3:   cal_d.c3    = cfg_i.data;
        CfgC4:   cal_d.c4    = cfg_i.data;
        CfgC5:   cal_d.c5    = cfg_i.data;
        CfgC6:   cal_d.c6    = cfg_i.data;
        CfgSoEn: cal_d.so_en = cfg_i.data[0];
        default: cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '{c1: '0, c2: '0, c3: '0, c4: '0, c5: '0, c6: '0, so_en: 1'b1};
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

/* hw/rtl/bpc_pipe_ctrl.sv */
module bpc_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpc_pkg::stage_en_t  en_o
);
  import bpc_pkg::*;

  stage_en_t valid_d, valid_q;
  stage_en_t stage_ready;

  // A stage may load when it is empty or when its content moves on, so
  // bubbles are squeezed out and a waiting result does not block the input.
  always_comb begin
    stage_ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (stage_ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign en_o        = stage_ready;
  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

/* hw/rtl/bpc_coef_stages.sv */
module bpc_coef_stages (
  input  logic                      clk_i,
  input  bpc_pkg::stage_en_t        en_i,
  input  bpc_pkg::cal_t             cal_i,
  input  logic [bpc_pkg::RawW-1:0]  raw_pressure_i,
  input  logic [bpc_pkg::RawW-1:0]  raw_temperature_i,
  output bpc_pkg::coef_res_t        res_o
);
  import bpc_pkg::*;

  // Stage 1: temperature difference.
  logic signed [DtW-1:0] dt_d, dt_q;
  logic [RawW-1:0]       d1_s1_q;

  // Stage 2: products of dT.
  logic signed [CoefProdW-1:0] m6_d, m4_d, m3_d, m6_q, m4_q, m3_q;
  logic signed [DtSqW-1:0]     mdd_d, mdd_q;
  logic [RawW-1:0]             d1_s2_q;

  // Stage 3: first-order temperature, offset and sensitivity.
  logic signed [CoefProdW-1:0] sh6, sh4, sh3;
  logic signed [TempW-1:0]     temp1_d, temp1_s3_q;
  logic signed [OffW-1:0]      off1_d, sens1_d, off1_s3_q, sens1_s3_q;
  logic [T2W-1:0]              t2_s3_q;
  logic [RawW-1:0]             d1_s3_q;

  // Stage 4: squares for the low-temperature terms.
  logic signed [TempExtW-1:0]  a_diff, b_diff;
  logic signed [TempSqW-1:0]   a_sq, b_sq;
  logic [SqW-1:0]              sq_s4_q, sq2_s4_q;
  logic                        low_d, vlow_d, low_s4_q, vlow_s4_q;
  logic signed [TempW-1:0]     temp1_s4_q;
  logic signed [OffW-1:0]      off1_s4_q, sens1_s4_q;
  logic [T2W-1:0]              t2_s4_q;
  logic [RawW-1:0]             d1_s4_q;

  // Stage 5: second-order corrections.
  logic [OffW-1:0]             sq5, sq2x7, sq2x11, off2_d, sens2_d, off2_q, sens2_q;
  logic signed [TempW-1:0]     temp_d, temp_s5_q;
  logic signed [OffW-1:0]      off1_s5_q, sens1_s5_q;
  logic [RawW-1:0]             d1_s5_q;

  // Stage 6: corrected offset and sensitivity.
  logic signed [OffW-1:0]      off_d, sens_d, off_q, sens_q;
  logic signed [TempW-1:0]     temp_s6_q;
  logic [RawW-1:0]             d1_s6_q;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.c5, 8'd0});

  assign m6_d  = dt_q * $signed({1'b0, cal_i.c6});
  assign m4_d  = dt_q * $signed({1'b0, cal_i.c4});
  assign m3_d  = dt_q * $signed({1'b0, cal_i.c3});
  assign mdd_d = dt_q * dt_q;

  assign sh6     = m6_q >>> 23;
  assign sh4     = m4_q >>> 7;
  assign sh3     = m3_q >>> 8;
  assign temp1_d = TempBase + $signed(sh6[TempW-1:0]);
  assign off1_d  = $signed({{(OffW-CalW-16){1'b0}}, cal_i.c2, 16'd0})
                 + $signed(sh4[OffW-1:0]);
  assign sens1_d = $signed({{(OffW-CalW-15){1'b0}}, cal_i.c1, 15'd0})
                 + $signed(sh3[OffW-1:0]);

  // The squares are only used below the thresholds, where they fit in SqW bits.
  assign a_diff = $signed({temp1_s3_q[TempW-1], temp1_s3_q})
                - $signed({TempBase[TempW-1], TempBase});
  assign b_diff = $signed({temp1_s3_q[TempW-1], temp1_s3_q})
                - $signed({TempVeryLow[TempW-1], TempVeryLow});
  assign a_sq   = a_diff * a_diff;
  assign b_sq   = b_diff * b_diff;
  assign low_d  = cal_i.so_en && (temp1_s3_q < TempBase);
  assign vlow_d = temp1_s3_q < TempVeryLow;

  always_comb begin
    sq5    = {{(OffW-SqW){1'b0}}, sq_s4_q} + {{(OffW-SqW-2){1'b0}}, sq_s4_q, 2'b00};
    sq2x7  = {{(OffW-SqW-3){1'b0}}, sq2_s4_q, 3'b000} - {{(OffW-SqW){1'b0}}, sq2_s4_q};
    sq2x11 = {{(OffW-SqW-3){1'b0}}, sq2_s4_q, 3'b000}
           + {{(OffW-SqW-1){1'b0}}, sq2_s4_q, 1'b0}
           + {{(OffW-SqW){1'b0}}, sq2_s4_q};
    off2_d  = '0;
    sens2_d = '0;
    temp_d  = temp1_s4_q;
    if (low_s4_q) begin
      off2_d  = sq5 >> 1;
      sens2_d = sq5 >> 2;
      temp_d  = temp1_s4_q - $signed({{(TempW-T2W){1'b0}}, t2_s4_q});
      if (vlow_s4_q) begin
        off2_d  = (sq5 >> 1) + sq2x7;
        sens2_d = (sq5 >> 2) + (sq2x11 >> 1);
      end
    end
  end

  assign off_d  = off1_s5_q - $signed(off2_q);
  assign sens_d = sens1_s5_q - $signed(sens2_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_pressure_i;
    end
    if (en_i[1]) begin
      m6_q    <= m6_d;
      m4_q    <= m4_d;
      m3_q    <= m3_d;
      mdd_q   <= mdd_d;
      d1_s2_q <= d1_s1_q;
    end
    if (en_i[2]) begin
      temp1_s3_q <= temp1_d;
      off1_s3_q  <= off1_d;
      sens1_s3_q <= sens1_d;
      t2_s3_q    <= mdd_q[31+T2W-1:31];
      d1_s3_q    <= d1_s2_q;
    end
    if (en_i[3]) begin
      sq_s4_q    <= a_sq[SqW-1:0];
      sq2_s4_q   <= b_sq[SqW-1:0];
      low_s4_q   <= low_d;
      vlow_s4_q  <= vlow_d;
      temp1_s4_q <= temp1_s3_q;
      off1_s4_q  <= off1_s3_q;
      sens1_s4_q <= sens1_s3_q;
      t2_s4_q    <= t2_s3_q;
      d1_s4_q    <= d1_s3_q;
    end
    if (en_i[4]) begin
      off2_q     <= off2_d;
      sens2_q    <= sens2_d;
      temp_s5_q  <= temp_d;
      off1_s5_q  <= off1_s4_q;
      sens1_s5_q <= sens1_s4_q;
      d1_s5_q    <= d1_s4_q;
    end
    if (en_i[5]) begin
      off_q     <= off_d;
      sens_q    <= sens_d;
      temp_s6_q <= temp_s5_q;
      d1_s6_q   <= d1_s5_q;
    end
  end

  assign res_o.d1   = d1_s6_q;
  assign res_o.off  = off_q;
  assign res_o.sens = sens_q;
  assign res_o.temp = temp_s6_q;

endmodule

/* hw/rtl/bpc_press_stages.sv */
module bpc_press_stages (
  input  logic                              clk_i,
  input  bpc_pkg::stage_en_t                en_i,
  input  bpc_pkg::coef_res_t                coef_i,
  output logic signed [bpc_pkg::PressW-1:0] pressure_o,
  output logic signed [bpc_pkg::TempW-1:0]  temperature_o
);
  import bpc_pkg::*;

  // Stage 7: D1 * SENS as two partial products.
  logic [PartLoW-1:0]          pp_lo_d, pp_lo_q;
  logic signed [PartHiW-1:0]   pp_hi_d, pp_hi_q;
  logic signed [OffW-1:0]      off_s7_q;
  logic signed [TempW-1:0]     temp_s7_q;

  // Stage 8: full product.
  logic [PartHiW+PartW-1:0]    hi_ext;
  logic signed [ProdW-1:0]     prod_d, prod_q;
  logic signed [OffW-1:0]      off_s8_q;
  logic signed [TempW-1:0]     temp_s8_q;

  // Stage 9: scaled product minus offset.
  logic signed [ProdW-1:0]     prod_sh;
  logic signed [DiffW-1:0]     diff_d, diff_q;
  logic signed [TempW-1:0]     temp_s9_q;

  // Stage 10: output register.
  logic signed [DiffW-1:0]     diff_sh;
  logic signed [PressW-1:0]    press_q;
  logic signed [TempW-1:0]     temp_s10_q;

  assign pp_lo_d = coef_i.d1 * coef_i.sens[PartW-1:0];
  assign pp_hi_d = $signed({1'b0, coef_i.d1}) * $signed(coef_i.sens[OffW-1:PartW]);

  assign hi_ext = {pp_hi_q, {PartW{1'b0}}};
  assign prod_d = $signed(hi_ext[ProdW-1:0])
                + $signed({{(ProdW-PartLoW){1'b0}}, pp_lo_q});

  assign prod_sh = prod_q >>> 21;
  assign diff_d  = $signed(prod_sh[DiffW-1:0])
                 - $signed({{(DiffW-OffW){off_s8_q[OffW-1]}}, off_s8_q});

  // The difference stays well inside 44 bits, so after the final shift the
  // pressure always lies within the 32-bit range and never saturates.
  assign diff_sh = diff_q >>> 15;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      pp_lo_q   <= pp_lo_d;
      pp_hi_q   <= pp_hi_d;
      off_s7_q  <= coef_i.off;
      temp_s7_q <= coef_i.temp;
    end
    if (en_i[7]) begin
      prod_q    <= prod_d;
      off_s8_q  <= off_s7_q;
      temp_s8_q <= temp_s7_q;
    end
    if (en_i[8]) begin
      diff_q    <= diff_d;
      temp_s9_q <= temp_s8_q;
    end
    if (en_i[9]) begin
      press_q    <= $signed(diff_sh[PressW-1:0]);
      temp_s10_q <= temp_s9_q;
    end
  end

  assign pressure_o    = press_q;
  assign temperature_o = temp_s10_q;

endmodule

/* hw/rtl/baro_pressure_temp_compensation_top.sv */
// Barometer compensation: each request carries one raw pressure conversion
// D1 and one raw temperature conversion D2 and yields one result holding the
// compensated pressure in 0.01 mbar and the temperature in 0.01 C. The six
// calibration words and the second-order enable are written through the
// configuration channel; the user must write them only while no request is
// in flight, as the block does not enforce it. The enable resets to on and
// the calibration words to zero. The datapath is a ten-stage pipeline that
// takes one request per cycle unless a stalled output has filled it. The
// depth is set by the chain dT, first-order terms, squares for the
// low-temperature correction, and the D1 by sensitivity product, which is
// built from two partial products over two stages. Results leave in request
// order, and a stalled output only holds the pipeline as far as it is full.
module baro_pressure_temp_compensation_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpc_in_if.sink    in_i,
  bpc_out_if.source out_o,
  bpc_cfg_if.sink   cfg_i
);
  import bpc_pkg::*;

  cal_t      cal;
  stage_en_t stage_en;
  coef_res_t coef_res;
  logic      in_ready;
  logic      out_valid;

  bpc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cal_o  (cal)
  );

  bpc_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .en_o        (stage_en)
  );

  bpc_coef_stages u_coef_stages (
    .clk_i             (clk_i),
    .en_i              (stage_en),
    .cal_i             (cal),
    .raw_pressure_i    (in_i.raw_pressure),
    .raw_temperature_i (in_i.raw_temperature),
    .res_o             (coef_res)
  );

  bpc_press_stages u_press_stages (
    .clk_i         (clk_i),
    .en_i          (stage_en),
    .coef_i        (coef_res),
    .pressure_o    (out_o.pressure_centi_mbar),
    .temperature_o (out_o.temperature_centi_deg)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

/* hw/rtl/bpc_checker.sv */
module bpc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [bpc_pkg::PressW-1:0] out_pressure,
  input logic signed [bpc_pkg::TempW-1:0]  out_temperature
);
  import bpc_pkg::*;

  localparam int unsigned CntW = $clog2(NumStages + 1);

  logic [CntW-1:0] inflight_d, inflight_q;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + CntW'(1);
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure)
                                && $stable(out_temperature))
    else $error("result dropped or changed while stalled");

  // With the output side empty the whole pipeline can move, so input is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked although no result is waiting");

  // No result without a request still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> inflight_q != '0)
    else $error("result shown without an outstanding request");

  // The pipeline never holds more requests than it has stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(NumStages))
    else $error("more requests in flight than pipeline stages");

endmodule

bind baro_pressure_temp_compensation_top bpc_checker u_bpc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_pressure    (out_o.pressure_centi_mbar),
  .out_temperature (out_o.temperature_centi_deg)
);

/* test/tb_baro_pressure_temp_compensation_top.sv */
module tb_baro_pressure_temp_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int HalfPeriod  = 2;
  localparam int ResetCycles = 5;
  localparam int QuietLimit  = 2000;
  localparam int NumPhases   = 9;
  localparam int PhaseItems  = 48;
  localparam int NumRows     = 23;
  localparam int NumIdx      = 1 << CfgIdxW;
  localparam int unsigned RawMax = (1 << RawW) - 1;

  // Scaling of the compensation terms.
  localparam int TempShift     = 23;
  localparam int OffCoefShift  = 7;
  localparam int SensCoefShift = 8;
  localparam int OffBaseShift  = 16;
  localparam int SensBaseShift = 15;
  localparam int DtSqShift     = 31;
  localparam int ProdShift     = 21;
  localparam int PressShift    = 15;
  localparam longint PressMax  = 64'sd2147483647;
  localparam longint PressMin  = -64'sd2147483648;

  localparam logic [CfgIdxW-1:0] CfgNoReg  = 3'd7;
  localparam logic [RawW-1:0]    TypicalD1 = 24'd9085466;
  localparam logic [RawW-1:0]    TypicalD2 = 24'd8569150;

  localparam cal_t CalReset   = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
  localparam cal_t CalOffset  = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
  localparam cal_t CalTypical = '{16'd40127, 16'd36924, 16'd23317, 16'd23282,
                                  16'd33464, 16'd28312, 1'b1};
  localparam cal_t CalMax     = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 1'b1};
  // With C5 and C6 both at 0x8000 the first-order temperature is 2000 + floor(dT / 256),
  // which puts the 20 C and -15 C thresholds on exact raw values.
  localparam cal_t CalCold    = '{16'd40127, 16'd36924, 16'd23317, 16'd23282,
                                  16'h8000, 16'h8000, 1'b1};
  localparam cal_t CalColdOff = '{16'd40127, 16'd36924, 16'd23317, 16'd23282,
                                  16'h8000, 16'h8000, 1'b0};

  typedef struct packed {
    logic signed [PressW-1:0] pressure;
    logic signed [TempW-1:0]  temperature;
  } reading_t;

  typedef struct packed {
    cal_t            cal;
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
    logic            typed;
    reading_t        want;
  } stim_row_t;

  localparam stim_row_t StimTable [NumRows] = '{
    '{CalReset,   24'h000000, 24'h000000, 1'b1, '{32'sd0, 19'sd2000}},
    '{CalReset,   24'hFFFFFF, 24'hFFFFFF, 1'b1, '{32'sd0, 19'sd2000}},
    '{CalReset,   24'hAAAAAA, 24'h555555, 1'b1, '{32'sd0, 19'sd2000}},
    '{CalOffset,  24'h000000, 24'h000000, 1'b1, '{-32'sd131070, 19'sd2000}},
    '{CalOffset,  24'hFFFFFF, 24'hFFFFFF, 1'b1, '{-32'sd131070, 19'sd2000}},
    '{CalTypical, TypicalD1,  TypicalD2,  1'b0, '0},
    '{CalTypical, 24'h000000, 24'h000000, 1'b0, '0},
    '{CalTypical, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{CalTypical, 24'h000000, 24'hFFFFFF, 1'b0, '0},
    '{CalTypical, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{CalMax,     24'h000000, 24'h000000, 1'b0, '0},
    '{CalMax,     24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{CalMax,     24'h555555, 24'hAAAAAA, 1'b0, '0},
    '{CalMax,     24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{CalCold,    TypicalD1,  24'd8388608, 1'b0, '0},
    '{CalCold,    TypicalD1,  24'd8388607, 1'b0, '0},
    '{CalCold,    TypicalD1,  24'd7492608, 1'b0, '0},
    '{CalCold,    TypicalD1,  24'd7492607, 1'b0, '0},
    '{CalCold,    24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{CalColdOff, TypicalD1,  24'd8388607, 1'b0, '0},
    '{CalColdOff, TypicalD1,  24'd7492607, 1'b0, '0},
    '{CalColdOff, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{CalReset,   24'h123456, 24'hFEDCBA, 1'b1, '{32'sd0, 19'sd2000}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bpc_in_if  in_if ();
  bpc_out_if out_if ();
  bpc_cfg_if cfg_if ();

  baro_pressure_temp_compensation_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  cal_t     cal_now = CalReset;
  reading_t pending_results [$];
  reading_t typed_val;
  reading_t want;
  bit       use_typed = 1'b0;
  int       stall_mode = 1;
  int       stall_left = 0;
  logic [7:0] stall_tick = '0;
  int       gap_max = 3;
  int       burst_left = 1;
  int       quiet_cycles = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_loads = 0;
  int       mismatches = 0;

  function automatic reading_t compensate(cal_t c, logic [RawW-1:0] d1_raw,
                                          logic [RawW-1:0] d2_raw);
    longint d1, dt, temp, off, sens, t2, off2, sens2, a, b, p;
    reading_t r;
    d1    = longint'(d1_raw);
    dt    = longint'(d2_raw) - (longint'(c.c5) << 8);
    temp  = longint'(TempBase) + ((dt * longint'(c.c6)) >>> TempShift);
    off   = (longint'(c.c2) << OffBaseShift) + ((dt * longint'(c.c4)) >>> OffCoefShift);
    sens  = (longint'(c.c1) << SensBaseShift) + ((dt * longint'(c.c3)) >>> SensCoefShift);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    // Both thresholds are tested on the first-order temperature.
    if (c.so_en && temp < longint'(TempBase)) begin
      a     = temp - longint'(TempBase);
      t2    = (dt * dt) >>> DtSqShift;
      off2  = (5 * a * a) >>> 1;
      sens2 = (5 * a * a) >>> 2;
      if (temp < longint'(TempVeryLow)) begin
        b     = temp - longint'(TempVeryLow);
        off2  = off2 + 7 * b * b;
        sens2 = sens2 + ((11 * b * b) >>> 1);
      end
    end
    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    p = (((d1 * sens) >>> ProdShift) - off) >>> PressShift;
    if (p > PressMax) p = PressMax;
    if (p < PressMin) p = PressMin;
    r.pressure    = p[PressW-1:0];
    r.temperature = temp[TempW-1:0];
    return r;
  endfunction

  function automatic logic [RawW-1:0] pick_pressure_raw();
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(9);
    if (sel == 8) return '0;
    if (sel == 9) return '1;
    if (sel < 6) return RawW'($urandom_range(RawMax));
    v = int'(TypicalD1) - (1 << 20) + $urandom_range(1 << 21);
    return v[RawW-1:0];
  endfunction

  function automatic logic [RawW-1:0] pick_temp_raw(logic [CalW-1:0] c5);
    int unsigned sel;
    longint v;
    sel = $urandom_range(9);
    if (sel == 8) return '0;
    if (sel == 9) return '1;
    if (sel < 4) return RawW'($urandom_range(RawMax));
    // A log-spread distance from the reference point, mostly on the cold side, so that
    // readings land near 20 C, between the thresholds and well below -15 C.
    v = longint'($urandom_range(1 << $urandom_range(RawW - 1)));
    if ($urandom_range(9) < 7) v = -v;
    v = v + (longint'(c5) << 8);
    if (v < 0) v = 0;
    if (v > longint'(RawMax)) v = longint'(RawMax);
    return v[RawW-1:0];
  endfunction

  // Called at a falling edge; returns at a falling edge with the request valid still
  // raised unless a gap was taken.
  task automatic send_item(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    int gap;
    in_if.valid           <= 1'b1;
    in_if.raw_pressure    <= d1;
    in_if.raw_temperature <= d2;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(20, 1);
      gap = $urandom_range(gap_max);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CalW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
  endtask

  // Writes every register, the unused index included, in a shuffled order.
  task automatic load_cal(input cal_t c);
    logic [CfgIdxW-1:0] order [NumIdx];
    logic [CfgIdxW-1:0] tmp;
    logic [CalW-1:0]    val;
    int i, j;
    for (i = 0; i < NumIdx; i++) order[i] = CfgIdxW'(i);
    for (i = NumIdx - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (i = 0; i < NumIdx; i++) begin
      case (cfg_idx_e'(order[i]))
        CfgC1:   val = c.c1;
        CfgC2:   val = c.c2;
        CfgC3:   val = c.c3;
        CfgC4:   val = c.c4;
        CfgC5:   val = c.c5;
        CfgC6:   val = c.c6;
        CfgSoEn: val = {15'($urandom_range(32767)), c.so_en};
        default: val = CalW'($urandom_range(65535));
      endcase
      cfg_write(order[i], val);
    end
    cfg_if.valid <= 1'b0;
    n_loads++;
  endtask

  // Result side: each result accepted here is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pressure %0d temperature %0d",
                   $time, out_if.pressure_centi_mbar, out_if.temperature_centi_deg);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (out_if.pressure_centi_mbar !== want.pressure) begin
            $display("%0t: pressure mismatch, expected %0d, got %0d",
                     $time, want.pressure, out_if.pressure_centi_mbar);
            mismatches++;
          end
          if (out_if.temperature_centi_deg !== want.temperature) begin
            $display("%0t: temperature mismatch, expected %0d, got %0d",
                     $time, want.temperature, out_if.temperature_centi_deg);
            mismatches++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (use_typed) begin
          pending_results.push_back(typed_val);
        end else begin
          pending_results.push_back(compensate(cal_now, in_if.raw_pressure,
                                               in_if.raw_temperature));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          CfgC1:   cal_now.c1 = cfg_if.data;
          CfgC2:   cal_now.c2 = cfg_if.data;
          CfgC3:   cal_now.c3 = cfg_if.data;
          CfgC4:   cal_now.c4 = cfg_if.data;
          CfgC5:   cal_now.c5 = cfg_if.data;
          CfgC6:   cal_now.c6 = cfg_if.data;
          CfgSoEn: cal_now.so_en = cfg_if.data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no request moved for %0d cycles, %0d results outstanding",
               $time, QuietLimit, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output stalls follow a pattern chosen per phase, independent of the sender.
  always @(negedge clk_i) begin
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(9) > 2);
      2: begin
        stall_tick   <= stall_tick + 8'd1;
        out_if.ready <= (stall_tick[2:0] > 3'd2);
      end
      default: begin
        if (stall_left != 0) begin
          stall_left   <= stall_left - 1;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
          if ($urandom_range(15) == 0) stall_left <= $urandom_range(30, 8);
        end
      end
    endcase
  end

  initial begin
    cal_t cal;
    int ph, i, r, pause_at;
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.raw_pressure    = '0;
    in_if.raw_temperature = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = '0;
    cfg_if.data           = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The first rows run on the values left by reset.
    for (r = 0; r < NumRows; r++) begin
      if (StimTable[r].cal != cal_now) begin
        drain();
        load_cal(StimTable[r].cal);
      end
      use_typed = StimTable[r].typed;
      typed_val = StimTable[r].want;
      send_item(StimTable[r].d1, StimTable[r].d2);
    end
    use_typed = 1'b0;

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph % 5)
        1: cal = CalTypical;
        2: cal = CalMax;
        3: cal = CalReset;
        default: cal = '{CalW'($urandom_range(65535)), CalW'($urandom_range(65535)),
                         CalW'($urandom_range(65535)), CalW'($urandom_range(65535)),
                         CalW'($urandom_range(65535)), CalW'($urandom_range(65535)), 1'b1};
      endcase
      cal.so_en = (ph % 4 < 2) || (ph % 5 == 2);
      drain();
      load_cal(cal);
      stall_mode <= ph % 4;
      case (ph % 3)
        0: gap_max = 0;
        1: gap_max = 4;
        default: gap_max = 12;
      endcase
      pause_at = $urandom_range(PhaseItems - 1);
      for (i = 0; i < PhaseItems; i++) begin
        if (i == pause_at) drain();
        send_item(pick_pressure_raw(), pick_temp_raw(cal.c5));
      end
    end

    drain();
    repeat (2 * NumStages) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches++;
    end
    $display("Sent %0d raw pairs, %0d of them from the directed rows, across %0d calibration loads",
             n_sent, NumRows, n_loads);
    $display("with second-order correction on and off; %0d readings compared, %0d mismatches.",
             n_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_in_if.sv
hw/rtl/bpc_out_if.sv
hw/rtl/bpc_cfg_if.sv
hw/rtl/bpc_cfg_regs.sv
hw/rtl/bpc_pipe_ctrl.sv
hw/rtl/bpc_coef_stages.sv
hw/rtl/bpc_press_stages.sv
hw/rtl/baro_pressure_temp_compensation_top.sv
hw/rtl/bpc_checker.sv
test/tb_baro_pressure_temp_compensation_top.sv
